// ===== rtl/core/grid_rect_first_fit_allocator_defines.svh =====
// Assertion macros for the allocator's checker file.
`ifndef GRID_RECT_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define GRID_RECT_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GRFFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GRFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/grffa_pkg.sv =====
// Types and constants of the rectangle first-fit grid allocator.
package grffa_pkg;

    // Payload field widths
    localparam int ID_W   = 32;
    localparam int POS_W  = 4;
    localparam int SIZE_W = 5;
    localparam int MODE_W = 2;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 16;

    // Place limits and the counters that walk a placed rectangle
    localparam int PLACE_W_MAX = 2;
    localparam int PLACE_H_MAX = 4;
    localparam int I_W = 1;
    localparam int J_W = 2;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PLACE  = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PL_RD,
        ST_PL_CHK,
        ST_PL_WR,
        ST_SWEEP,
        ST_FIND,
        ST_RESP
    } t_state;

endpackage

// ===== rtl/core/grid_rect_first_fit_allocator.sv =====
// Rectangle first-fit allocator over a grid of 32-bit occupant cells.
//
// Input stream (s_axis): one command per item. tuser carries the mode
// (place, remove, find, clear); tdata carries id, position and size.
// Output stream (m_axis): exactly one result per command: ok, found_x,
// found_y. Commands run one at a time; s_axis_tready is high only while
// the sequencer is idle.
// Remove and find each sweep the whole grid through the single read port
// of the grid memory, one cell a cycle; clear writes every cell; a place
// reads and writes each cell of its rectangle in turn, and sweeps the
// whole grid once for every occupied cell met, to evict its occupant.
// Reset starts a clearing pass that writes every cell to empty; no item
// is accepted until it ends.
// The result sits in an output register; a stalled receiver holds it there,
// and the next command may be taken meanwhile but waits before its own
// result is loaded until the register is free.
module grid_rect_first_fit_allocator #(
    parameter int GRID_W = 16,
    parameter int GRID_H = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: item_id[31:0], pos_x[35:32], pos_y[39:36], size_w[44:40],
    //        size_h[49:45], zero fill [55:50]
    input  logic [grffa_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [grffa_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: ok[0], found_x[4:1], found_y[8:5], zero fill [15:9]
    output logic [grffa_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import grffa_pkg::*;

    localparam int CELLS  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);
    localparam int XC_W   = $clog2(GRID_W + 1);
    localparam int YC_W   = $clog2(GRID_H + 1);
    localparam int CMP_W  = (XC_W > YC_W) ? ((XC_W > 6) ? XC_W : 6)
                                          : ((YC_W > 6) ? YC_W : 6);

    // Grid memory and column free-depth memory
    logic [ID_W-1:0]  r_grid [CELLS];
    logic [CMP_W-1:0] r_down [GRID_W];

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_issue, n_issue;
    logic               r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]  r_rd_addr, n_rd_addr;
    logic [ID_W-1:0]    r_rd_data;
    logic [ID_W-1:0]    r_key, n_key;
    logic               r_to_place, n_to_place;
    logic               r_clr_resp, n_clr_resp;
    logic [ID_W-1:0]    r_id, n_id;
    logic [POS_W-1:0]   r_px, n_px, r_py, n_py;
    logic [SIZE_W-1:0]  r_w, n_w, r_h, n_h;
    logic [I_W-1:0]     r_i, n_i;
    logic [J_W-1:0]     r_j, n_j;
    logic [X_W-1:0]     r_x, n_x, r_xd, n_xd;
    logic [Y_W-1:0]     r_y, n_y, r_yd, n_yd;
    logic [CMP_W-1:0]   r_run, n_run;
    logic               r_row_hit, n_row_hit;
    logic               r_ok, n_ok;
    logic [POS_W-1:0]   r_fx, n_fx, r_fy, n_fy;
    logic               r_out_vld, n_out_vld;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    // Memory port controls
    logic               w_grid_re, w_grid_we;
    logic [ADDR_W-1:0]  w_grid_raddr, w_grid_waddr;
    logic [ID_W-1:0]    w_grid_wdata;
    logic               w_down_re, w_down_we;
    logic [X_W-1:0]     w_down_raddr, w_down_waddr;
    logic [CMP_W-1:0]   w_down_wdata;
    logic [CMP_W-1:0]   r_down_rd;

    // Input fields
    t_mode              w_mode;
    logic [ID_W-1:0]    w_in_id;
    logic [POS_W-1:0]   w_in_px, w_in_py;
    logic [SIZE_W-1:0]  w_in_w, w_in_h;
    logic               w_place_ok;

    // Datapath helpers
    logic [CMP_W-1:0]   w_pl_xx, w_pl_yy;
    logic [ADDR_W-1:0]  w_pl_addr, w_find_addr;
    logic [CMP_W-1:0]   w_new_down, w_run_base, w_run_new;
    logic               w_col_ok, w_hit;

    assign w_mode  = t_mode'(i_s_axis_tuser[MODE_W-1:0]);
    assign w_in_id = i_s_axis_tdata[31:0];
    assign w_in_px = i_s_axis_tdata[35:32];
    assign w_in_py = i_s_axis_tdata[39:36];
    assign w_in_w  = i_s_axis_tdata[44:40];
    assign w_in_h  = i_s_axis_tdata[49:45];

    // Check a place command for a nonzero ID, the size limits and the grid bounds
    assign w_place_ok = (w_in_id != '0)
        && (w_in_w >= SIZE_W'(1)) && (w_in_w <= SIZE_W'(PLACE_W_MAX))
        && (w_in_h >= SIZE_W'(1)) && (w_in_h <= SIZE_W'(PLACE_H_MAX))
        && ((CMP_W'(w_in_px) + CMP_W'(w_in_w)) <= CMP_W'(GRID_W))
        && ((CMP_W'(w_in_py) + CMP_W'(w_in_h)) <= CMP_W'(GRID_H));

    // Address of the place cell under visit, and of the find scan position
    assign w_pl_xx   = CMP_W'(r_px) + CMP_W'(r_i);
    assign w_pl_yy   = CMP_W'(r_py) + CMP_W'(r_j);
    assign w_pl_addr = ADDR_W'(ADDR_W'(w_pl_yy) * ADDR_W'(GRID_W) + ADDR_W'(w_pl_xx));
    assign w_find_addr = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(GRID_W) + ADDR_W'(r_x));

    // Find: free depth below each cell, then run of deep-enough columns
    assign w_new_down = (r_rd_data != '0)
        ? '0
        : ((r_yd == Y_W'(GRID_H - 1)) ? CMP_W'(1) : r_down_rd + CMP_W'(1));
    assign w_col_ok   = (w_new_down >= CMP_W'(r_h));
    assign w_run_base = (r_xd == '0) ? '0 : r_run;
    assign w_run_new  = w_col_ok ? w_run_base + CMP_W'(1) : '0;
    assign w_hit      = (w_run_new >= CMP_W'(r_w)) && !((r_xd != '0) && r_row_hit);

    // Grid memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_grid_we) begin
            r_grid[w_grid_waddr] <= w_grid_wdata;
        end
        if (w_grid_re) begin
            r_rd_data <= r_grid[w_grid_raddr];
        end
    end

    // Column depth memory
    always_ff @(posedge i_clk) begin
        if (w_down_we) begin
            r_down[w_down_waddr] <= w_down_wdata;
        end
        if (w_down_re) begin
            r_down_rd <= r_down[w_down_raddr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_to_place <= 1'b0;
            r_clr_resp <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_issue    <= n_issue;
            r_rd_vld   <= n_rd_vld;
            r_to_place <= n_to_place;
            r_clr_resp <= n_clr_resp;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_key      <= n_key;
        r_id       <= n_id;
        r_px       <= n_px;
        r_py       <= n_py;
        r_w        <= n_w;
        r_h        <= n_h;
        r_i        <= n_i;
        r_j        <= n_j;
        r_x        <= n_x;
        r_y        <= n_y;
        r_xd       <= n_xd;
        r_yd       <= n_yd;
        r_run      <= n_run;
        r_row_hit  <= n_row_hit;
        r_ok       <= n_ok;
        r_fx       <= n_fx;
        r_fy       <= n_fy;
        r_out_data <= n_out_data;
    end

    // Sequencer: next state, memory controls and datapath updates
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_rd_vld   = r_rd_vld;
        n_rd_addr  = r_rd_addr;
        n_key      = r_key;
        n_to_place = r_to_place;
        n_clr_resp = r_clr_resp;
        n_id       = r_id;
        n_px       = r_px;
        n_py       = r_py;
        n_w        = r_w;
        n_h        = r_h;
        n_i        = r_i;
        n_j        = r_j;
        n_x        = r_x;
        n_y        = r_y;
        n_xd       = r_xd;
        n_yd       = r_yd;
        n_run      = r_run;
        n_row_hit  = r_row_hit;
        n_ok       = r_ok;
        n_fx       = r_fx;
        n_fy       = r_fy;
        n_out_data = r_out_data;
        n_out_vld  = r_out_vld;

        w_grid_re    = 1'b0;
        w_grid_raddr = r_addr;
        w_grid_we    = 1'b0;
        w_grid_waddr = r_addr;
        w_grid_wdata = '0;
        w_down_re    = 1'b0;
        w_down_raddr = r_x;
        w_down_we    = 1'b0;
        w_down_waddr = r_xd;
        w_down_wdata = w_new_down;

        o_s_axis_tready = 1'b0;

        // Drop the result once the receiver takes it
        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // Write one cell empty per cycle
                w_grid_we = 1'b1;
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = r_clr_resp ? ST_RESP : ST_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_id       = w_in_id;
                    n_px       = w_in_px;
                    n_py       = w_in_py;
                    n_w        = w_in_w;
                    n_h        = w_in_h;
                    n_ok       = 1'b0;
                    n_fx       = '0;
                    n_fy       = '0;
                    n_addr     = '0;
                    n_rd_vld   = 1'b0;
                    n_clr_resp = 1'b0;
                    unique case (w_mode)
                        MODE_PLACE: begin
                            n_i = '0;
                            n_j = '0;
                            n_state = w_place_ok ? ST_PL_RD : ST_RESP;
                        end
                        MODE_REMOVE: begin
                            if (w_in_id != '0) begin
                                n_key      = w_in_id;
                                n_issue    = 1'b1;
                                n_to_place = 1'b0;
                                n_ok       = 1'b1;
                                n_state    = ST_SWEEP;
                            end else begin
                                n_state = ST_RESP;
                            end
                        end
                        MODE_FIND: begin
                            if ((w_in_w != '0) && (w_in_h != '0)) begin
                                n_x     = '0;
                                n_y     = Y_W'(GRID_H - 1);
                                n_issue = 1'b1;
                                n_state = ST_FIND;
                            end else begin
                                n_state = ST_RESP;
                            end
                        end
                        MODE_CLEAR: begin
                            n_ok       = 1'b1;
                            n_clr_resp = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            ST_PL_RD: begin
                // Read the cell about to be written
                w_grid_re    = 1'b1;
                w_grid_raddr = w_pl_addr;
                n_state      = ST_PL_CHK;
            end

            ST_PL_CHK: begin
                // Evict the occupant everywhere before writing over it
                if (r_rd_data != '0) begin
                    n_key      = r_rd_data;
                    n_addr     = '0;
                    n_issue    = 1'b1;
                    n_rd_vld   = 1'b0;
                    n_to_place = 1'b1;
                    n_state    = ST_SWEEP;
                end else begin
                    n_state = ST_PL_WR;
                end
            end

            ST_PL_WR: begin
                w_grid_we    = 1'b1;
                w_grid_waddr = w_pl_addr;
                w_grid_wdata = r_id;
                if (r_i == I_W'(r_w - SIZE_W'(1))) begin
                    n_i = '0;
                    if (r_j == J_W'(r_h - SIZE_W'(1))) begin
                        n_ok    = 1'b1;
                        n_state = ST_RESP;
                    end else begin
                        n_j     = r_j + J_W'(1);
                        n_state = ST_PL_RD;
                    end
                end else begin
                    n_i     = r_i + I_W'(1);
                    n_state = ST_PL_RD;
                end
            end

            ST_SWEEP: begin
                // Issue reads in address order
                if (r_issue) begin
                    w_grid_re    = 1'b1;
                    w_grid_raddr = r_addr;
                    n_rd_vld     = 1'b1;
                    n_rd_addr    = r_addr;
                    if (r_addr == ADDR_W'(CELLS - 1)) begin
                        n_issue = 1'b0;
                        n_addr  = '0;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                // Clear the cell read last cycle if it holds the key
                if (r_rd_vld && (r_rd_data == r_key)) begin
                    w_grid_we    = 1'b1;
                    w_grid_waddr = r_rd_addr;
                    w_grid_wdata = '0;
                end
                if (!r_issue) begin
                    n_state = r_to_place ? ST_PL_WR : ST_RESP;
                end
            end

            ST_FIND: begin
                // Scan rows bottom-up, columns left to right
                if (r_issue) begin
                    w_grid_re    = 1'b1;
                    w_grid_raddr = w_find_addr;
                    w_down_re    = 1'b1;
                    w_down_raddr = r_x;
                    n_rd_vld     = 1'b1;
                    n_xd         = r_x;
                    n_yd         = r_y;
                    if (r_x == X_W'(GRID_W - 1)) begin
                        n_x = '0;
                        if (r_y == '0) begin
                            n_issue = 1'b0;
                        end else begin
                            n_y = r_y - Y_W'(1);
                        end
                    end else begin
                        n_x = r_x + X_W'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                // Update depth and run; keep the first hit of the topmost row
                if (r_rd_vld) begin
                    w_down_we = 1'b1;
                    n_run     = w_run_new;
                    n_row_hit = ((r_xd == '0) ? 1'b0 : r_row_hit) | w_hit;
                    if (w_hit) begin
                        n_ok = 1'b1;
                        n_fx = POS_W'(CMP_W'(r_xd) + CMP_W'(1) - CMP_W'(r_w));
                        n_fy = POS_W'(r_yd);
                    end
                end
                if (!r_issue) begin
                    n_state = ST_RESP;
                end
            end

            ST_RESP: begin
                // Load the result once the output register is free
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {(M_TDATA_W - 1 - 2 * POS_W)'(0), r_fy, r_fx, r_ok};
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/grffa_checker.sv =====
// Port-level checks of the grid allocator, bound to its top level.
`include "grid_rect_first_fit_allocator_defines.svh"

module grffa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    // tdata: item_id, pos_x, pos_y, size_w, size_h from the lowest bit up
    input logic [grffa_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode
    input logic [grffa_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    // tdata: ok, found_x, found_y from the lowest bit up
    input logic [grffa_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import grffa_pkg::*;

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // A stalled result stays and holds its value
    `GRFFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // A command occupies the sequencer: no back-to-back acceptance
    `GRFFA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_acc, !o_s_axis_tready, "input taken while busy")

    // A failed command reports no position
    `GRFFA_ASSERT_SAME(a_fail_no_pos, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[2*POS_W:1] == '0, "failed result carries a position")

endmodule

bind grid_rect_first_fit_allocator grffa_checker u_grffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== test/grffa_result_checker.sv =====
// Result checker for the grid allocator: models the occupancy grid and checks each result item.
`timescale 1ns / 100ps

module grffa_result_checker #(
    parameter int GRID_W = 16,
    parameter int GRID_H = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // tdata: item_id, pos_x, pos_y, size_w, size_h, zero fill
    input  logic [grffa_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: mode
    input  logic [grffa_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: ok, found_x, found_y, zero fill
    input  logic [grffa_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count
);
    import grffa_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] fx;
        logic [POS_W-1:0] fy;
    } t_alloc_result;

    // Occupant ID per cell, 0 for empty
    logic [ID_W-1:0] occ [GRID_H][GRID_W];
    t_alloc_result   awaited_results [$];
    int              fails = 0;
    int              results_seen = 0;

    // Empty every cell
    function automatic void wipe_grid();
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
                occ[y][x] = '0;
    endfunction

    // Drop an occupant from every cell it holds
    function automatic void evict_occupant(logic [ID_W-1:0] id);
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
                if (occ[y][x] == id) occ[y][x] = '0;
    endfunction

    // Treat cells beyond the grid edge as taken
    function automatic bit rect_is_free(int x0, int y0, int w, int h);
        for (int x = x0; x < x0 + w; x++)
            for (int y = y0; y < y0 + h; y++) begin
                if (x >= GRID_W || y >= GRID_H) return 1'b0;
                if (occ[y][x] != '0) return 1'b0;
            end
        return 1'b1;
    endfunction

    // Apply one command to the grid copy and return its result
    function automatic t_alloc_result run_command(t_mode mode, logic [ID_W-1:0] id,
                                                  int px, int py, int w, int h);
        t_alloc_result   r;
        logic [ID_W-1:0] cur;
        bit              found;
        r = '0;
        found = 1'b0;
        case (mode)
            MODE_PLACE: begin
                if (id != '0 && w >= 1 && w <= PLACE_W_MAX && h >= 1 && h <= PLACE_H_MAX
                    && px + w <= GRID_W && py + h <= GRID_H) begin
                    // Visit row by row; an occupant met is evicted everywhere first
                    for (int j = 0; j < h; j++)
                        for (int i = 0; i < w; i++) begin
                            cur = occ[py + j][px + i];
                            if (cur != '0) evict_occupant(cur);
                            occ[py + j][px + i] = id;
                        end
                    r.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (id != '0) begin
                    evict_occupant(id);
                    r.ok = 1'b1;
                end
            end
            MODE_FIND: begin
                if (w != 0 && h != 0) begin
                    for (int y = 0; y < GRID_H && !found; y++)
                        for (int x = 0; x < GRID_W && !found; x++)
                            if (occ[y][x] == '0 && rect_is_free(x, y, w, h)) begin
                                found = 1'b1;
                                r.ok = 1'b1;
                                r.fx = POS_W'(x);
                                r.fy = POS_W'(y);
                            end
                end
            end
            default: begin
                wipe_grid();
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s mismatch on result %0d: expected %0d, actual %0d",
                     $time, name, results_seen, want, got);
        end
    endtask

    // Check result items, then predict for newly accepted command items
    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            wipe_grid();
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                got.ok = i_m_tdata[0];
                got.fx = i_m_tdata[1 +: POS_W];
                got.fy = i_m_tdata[1 + POS_W +: POS_W];
                if (awaited_results.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected result %0d: expected none, actual ok=%0d x=%0d y=%0d",
                             $time, results_seen, got.ok, got.fx, got.fy);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("ok", int'(want.ok), int'(got.ok));
                    compare_field("found_x", int'(want.fx), int'(got.fx));
                    compare_field("found_y", int'(want.fy), int'(got.fy));
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(run_command(
                    t_mode'(i_s_tuser),
                    i_s_tdata[ID_W-1:0],
                    int'(i_s_tdata[ID_W +: POS_W]),
                    int'(i_s_tdata[ID_W + POS_W +: POS_W]),
                    int'(i_s_tdata[ID_W + 2*POS_W +: SIZE_W]),
                    int'(i_s_tdata[ID_W + 2*POS_W + SIZE_W +: SIZE_W])));
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_results.size();
        o_result_count <= results_seen;
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the grid allocator: clock, reset, command stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module tb;
    import grffa_pkg::*;

    localparam int GRID_W       = 16;
    localparam int GRID_H       = 16;
    localparam int RANDOM_ITEMS = 1275;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;
    // Worst place evicts 8 occupants, plus the hold-off; take it several times over
    localparam int STALL_LIMIT  = 20000;
    localparam int FIELDS_W     = ID_W + 2*POS_W + 2*SIZE_W;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = MODE_PLACE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int              fail_count;
    int              pending;
    int              result_count;
    int              idle_cycles = 0;
    int              mode_count [4];
    bit              hold_req = 1'b0;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grid_rect_first_fit_allocator #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    grffa_result_checker #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) results_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Length of the next ready or stalled stretch on the result side
    function automatic int ready_run(bit ready);
        int r;
        r = $urandom_range(0, 99);
        if (ready) return (r < 85) ? $urandom_range(1, 6) : $urandom_range(20, 200);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    function automatic logic [ID_W-1:0] pool_id();
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Any ID, zero and fully random among them
    function automatic logic [ID_W-1:0] any_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 4) return $urandom;
        return pool_id();
    endfunction

    // Offer one command item and hold it until accepted
    task automatic send_cmd(t_mode mode, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - FIELDS_W){1'b0}}, h, w, y, x, id};
        do @(posedge clk); while (!s_tready);
        mode_count[mode]++;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int run_left;
        run_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                run_left = 0;
            end else if (run_left == 0) begin
                m_tready <= !m_tready;
                run_left = ready_run(!m_tready);
            end else begin
                run_left--;
            end
        end
    end

    // End the run when no item moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: watchdog expired, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        int w;
        int h;
        int x;
        int y;
        for (int m = 0; m < 4; m++) mode_count[m] = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
            if (id_pool[i] == '0) id_pool[i] = 32'h0000_0100;
        end
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h0000_0001;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: rejects, grid edges, evictions, self-overlap, find corners
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd1,  5'd1);
        send_cmd(MODE_PLACE,  32'h0,         4'd0,  4'd0,  5'd1,  5'd1);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd0,  4'd0,  5'd0,  5'd1);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd0,  4'd0,  5'd3,  5'd1);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd0,  4'd0,  5'd1,  5'd0);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd0,  4'd0,  5'd1,  5'd5);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd15, 4'd0,  5'd2,  5'd1);
        send_cmd(MODE_PLACE,  32'hA5A5_5A5A, 4'd0,  4'd13, 5'd1,  5'd4);
        send_cmd(MODE_PLACE,  32'hFFFF_FFFF, 4'd0,  4'd0,  5'd2,  5'd4);
        send_cmd(MODE_PLACE,  32'h0000_0001, 4'd14, 4'd12, 5'd2,  5'd4);
        send_cmd(MODE_PLACE,  32'h0000_0002, 4'd15, 4'd15, 5'd1,  5'd1);
        send_cmd(MODE_PLACE,  32'h0000_0003, 4'd1,  4'd3,  5'd2,  5'd2);
        send_cmd(MODE_PLACE,  32'h0000_0003, 4'd1,  4'd3,  5'd2,  5'd2);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd16, 5'd16);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd2,  5'd2);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd31, 5'd31);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd0,  5'd3);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd3,  5'd0);
        send_cmd(MODE_REMOVE, 32'h0,         4'd0,  4'd0,  5'd0,  5'd0);
        send_cmd(MODE_REMOVE, 32'h1234_5678, 4'd0,  4'd0,  5'd0,  5'd0);
        send_cmd(MODE_REMOVE, 32'h0000_0003, 4'd0,  4'd0,  5'd0,  5'd0);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd16, 5'd15);
        send_cmd(MODE_CLEAR,  32'h0,         4'd0,  4'd0,  5'd0,  5'd0);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd16, 5'd16);
        send_cmd(MODE_FIND,   32'h0,         4'd0,  4'd0,  5'd17, 5'd1);

        // Random: valid places on a shared ID pool half the time, else junk places, removes, finds, clears
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                w = $urandom_range(1, PLACE_W_MAX);
                h = $urandom_range(1, PLACE_H_MAX);
                x = $urandom_range(0, GRID_W - w);
                y = $urandom_range(0, GRID_H - h);
                send_cmd(MODE_PLACE, pool_id(), POS_W'(x), POS_W'(y), SIZE_W'(w), SIZE_W'(h));
            end else if (pick < 58) begin
                send_cmd(MODE_PLACE, any_id(),
                         POS_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 15)),
                         SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)));
            end else if (pick < 76) begin
                send_cmd(MODE_REMOVE, any_id(),
                         POS_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 15)),
                         SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)));
            end else if (pick < 97) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    w = $urandom_range(1, 4);
                    h = $urandom_range(1, 4);
                end else if (pick < 9) begin
                    w = $urandom_range(1, GRID_W);
                    h = $urandom_range(1, GRID_H);
                end else begin
                    w = $urandom_range(0, 31);
                    h = $urandom_range(0, 31);
                end
                send_cmd(MODE_FIND, $urandom,
                         POS_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 15)),
                         SIZE_W'(w), SIZE_W'(h));
            end else begin
                send_cmd(MODE_CLEAR, $urandom,
                         POS_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 15)),
                         SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)));
            end
        end

        // Drain outstanding results, then watch for strays
        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d place, %0d remove, %0d find, %0d clear.",
                 mode_count[MODE_PLACE] + mode_count[MODE_REMOVE] + mode_count[MODE_FIND]
                 + mode_count[MODE_CLEAR], mode_count[MODE_PLACE], mode_count[MODE_REMOVE],
                 mode_count[MODE_FIND], mode_count[MODE_CLEAR]);
        $display("Checked %0d results under random stalls and a %0d-cycle result hold-off.",
                 result_count, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
